// ----- src/dcu_pkg.sv -----
// shared types, codes and helper functions of the depth compare unit
// no dependencies; every other file of the block refers to this package

package dcu_pkg;

    localparam int DEPTH_W    = 18;
    localparam int DELTA_W    = 16;
    localparam int CODE_W     = 4;
    localparam int COV_W      = 4;
    localparam int MEM_COV_W  = 3;
    localparam int WORD_W     = 16;
    localparam int HIDDEN_W   = 2;
    localparam int SHIFT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX      = 18'h3ffff;
    localparam logic [DELTA_W-1:0] DELTA_COPLANAR = 16'hffff;
    localparam logic [CODE_W-1:0]  CODE_MAX       = 4'd15;
    localparam logic [CODE_W-1:0]  CODE_SHIFT_LIM = 4'd11;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX      = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMPARE_ENABLE       = 3'd0,
        CFG_DEPTH_MODE           = 3'd1,
        CFG_BLEND_ALWAYS         = 3'd2,
        CFG_ANTIALIAS_ENABLE     = 3'd3,
        CFG_SHIFTERS_UPDATE      = 3'd4,
        CFG_PAST_SHIFTERS_UPDATE = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_OPAQUE      = 2'd0,
        MODE_INTERPEN    = 2'd1,
        MODE_TRANSLUCENT = 2'd2,
        MODE_DECAL       = 2'd3
    } depth_mode_t;

    typedef struct packed {
        logic        compare_enable;
        depth_mode_t depth_mode;
        logic        blend_always;
        logic        antialias_enable;
        logic        shifters_update;
        logic        past_shifters_update;
    } cfg_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]   new_depth;
        logic [DELTA_W-1:0]   delta_depth;
        logic [CODE_W-1:0]    delta_code;
        logic [COV_W-1:0]     coverage;
        logic [MEM_COV_W-1:0] stored_coverage;
        logic [WORD_W-1:0]    stored_word;
        logic [HIDDEN_W-1:0]  stored_hidden;
    } item_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] old_depth;
        logic [CODE_W-1:0]  stored_code;
        logic [DELTA_W-1:0] stored_delta;
        logic               coplanar;
    } decoded_t;

    typedef struct packed {
        logic [CODE_W-1:0]  prev_code;
        logic [SHIFT_W-1:0] shift_a;
        logic [SHIFT_W-1:0] shift_b;
        logic [SHIFT_W-1:0] past_shift_a;
        logic [SHIFT_W-1:0] past_shift_b;
    } state_t;

    typedef struct packed {
        logic               pass;
        logic               blend_enable;
        logic               coverage_wrap;
        logic [COV_W-1:0]   coverage_out;
        logic [SHIFT_W-1:0] shift_a;
        logic [SHIFT_W-1:0] shift_b;
        logic [SHIFT_W-1:0] past_shift_a;
        logic [SHIFT_W-1:0] past_shift_b;
    } result_t;

    function automatic logic [2:0] exp_shift(input logic [2:0] e);
        logic [2:0] r;
        case (e)
            3'd0:    r = 3'd6;
            3'd1:    r = 3'd5;
            3'd2:    r = 3'd4;
            3'd3:    r = 3'd3;
            3'd4:    r = 3'd2;
            3'd5:    r = 3'd1;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DEPTH_W-1:0] exp_add(input logic [2:0] e);
        logic [DEPTH_W-1:0] r;
        case (e)
            3'd0:    r = 18'h00000;
            3'd1:    r = 18'h20000;
            3'd2:    r = 18'h30000;
            3'd3:    r = 18'h38000;
            3'd4:    r = 18'h3c000;
            3'd5:    r = 18'h3e000;
            3'd6:    r = 18'h3f000;
            default: r = 18'h3f800;
        endcase
        return r;
    endfunction

    function automatic logic [SHIFT_W-1:0] clamp_diff(input logic [CODE_W-1:0] a,
                                                      input logic [CODE_W-1:0] b);
        logic [CODE_W-1:0]  d;
        logic [SHIFT_W-1:0] r;
        d = a - b;
        if (a <= b)
            r = '0;
        else if (d > CODE_W'(SHIFT_MAX))
            r = SHIFT_MAX;
        else
            r = d[SHIFT_W-1:0];
        return r;
    endfunction

    // highest set bit kept, all others cleared
    function automatic logic [DELTA_W-1:0] top_bit(input logic [DELTA_W-1:0] v);
        logic [DELTA_W-1:0] r;
        r = '0;
        for (int k = 0; k < DELTA_W; k++)
        begin
            if (v[k])
                r = DELTA_W'(1) << k;
        end
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] log2_pow2(input logic [DELTA_W-1:0] v);
        logic [CODE_W-1:0] j;
        j[3] = |(v & 16'hff00);
        j[2] = |(v & 16'hf0f0);
        j[1] = |(v & 16'hcccc);
        j[0] = |(v & 16'haaaa);
        return j;
    endfunction

endpackage

// ----- src/dcu_pixel_if.sv -----
// valid/ready channel carrying one pixel beat into the depth compare unit
// depends on dcu_pkg for field widths

interface dcu_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [dcu_pkg::DEPTH_W-1:0]   new_depth;
    logic [dcu_pkg::DELTA_W-1:0]   delta_depth;
    logic [dcu_pkg::CODE_W-1:0]    delta_code;
    logic [dcu_pkg::COV_W-1:0]     coverage;
    logic [dcu_pkg::MEM_COV_W-1:0] stored_coverage;
    logic [dcu_pkg::WORD_W-1:0]    stored_word;
    logic [dcu_pkg::HIDDEN_W-1:0]  stored_hidden;

    modport source (
        output valid, new_depth, delta_depth, delta_code, coverage,
               stored_coverage, stored_word, stored_hidden,
        input  ready
    );

    modport sink (
        input  valid, new_depth, delta_depth, delta_code, coverage,
               stored_coverage, stored_word, stored_hidden,
        output ready
    );
endinterface

// ----- src/dcu_result_if.sv -----
// valid/ready channel carrying one result beat out of the depth compare unit
// depends on dcu_pkg for field widths

interface dcu_result_if;
    logic                        valid;
    logic                        ready;
    logic                        pass;
    logic                        blend_enable;
    logic                        coverage_wrap;
    logic [dcu_pkg::COV_W-1:0]   coverage_out;
    logic [dcu_pkg::SHIFT_W-1:0] shift_a;
    logic [dcu_pkg::SHIFT_W-1:0] shift_b;
    logic [dcu_pkg::SHIFT_W-1:0] past_shift_a;
    logic [dcu_pkg::SHIFT_W-1:0] past_shift_b;

    modport source (
        output valid, pass, blend_enable, coverage_wrap, coverage_out,
               shift_a, shift_b, past_shift_a, past_shift_b,
        input  ready
    );

    modport sink (
        input  valid, pass, blend_enable, coverage_wrap, coverage_out,
               shift_a, shift_b, past_shift_a, past_shift_b,
        output ready
    );
endinterface

// ----- src/dcu_depth_decode.sv -----
// expands the stored compressed depth word and rebuilds the stored slope
// depends on dcu_pkg (decoded_t, exponent tables)

module dcu_depth_decode (
    input  logic [dcu_pkg::WORD_W-1:0]   stored_word,
    input  logic [dcu_pkg::HIDDEN_W-1:0] stored_hidden,
    output dcu_pkg::decoded_t            dec
);

    logic [2:0]                   exponent;
    logic [dcu_pkg::DEPTH_W-1:0]  mantissa;
    logic [dcu_pkg::CODE_W-1:0]   code;
    logic [dcu_pkg::DELTA_W-1:0]  one_hot;
    logic [dcu_pkg::DELTA_W-1:0]  doubled;
    logic [dcu_pkg::DELTA_W-1:0]  floor_val;

    assign exponent  = stored_word[15:13];
    assign mantissa  = {7'd0, stored_word[12:2]};
    assign code      = {stored_word[1:0], stored_hidden};
    assign one_hot   = dcu_pkg::DELTA_W'(1) << code;
    assign doubled   = one_hot << 1;
    assign floor_val = dcu_pkg::DELTA_W'(16) >> exponent;

    always_comb
    begin
        dec.old_depth   = (mantissa << dcu_pkg::exp_shift(exponent))
                          + dcu_pkg::exp_add(exponent);
        dec.stored_code = code;
        dec.coplanar    = 1'b0;
        dec.stored_delta = one_hot;
        // small exponents widen the stored slope
        if (exponent < 3'd3)
        begin
            if (code == dcu_pkg::CODE_MAX)
            begin
                dec.coplanar     = 1'b1;
                dec.stored_delta = dcu_pkg::DELTA_COPLANAR;
            end
            else
            begin
                dec.stored_delta = (doubled > floor_val) ? doubled : floor_val;
            end
        end
    end

endmodule

// ----- src/dcu_compare.sv -----
// depth test, blend decision, coverage scaling and blender shift update
// depends on dcu_pkg (cfg_t, item_t, decoded_t, state_t, result_t)

module dcu_compare (
    input  dcu_pkg::cfg_t     cfg,
    input  dcu_pkg::item_t    item,
    input  dcu_pkg::decoded_t dec,
    input  dcu_pkg::state_t   state,
    output dcu_pkg::result_t  res,
    output dcu_pkg::state_t   state_next
);

    logic [4:0]                   cov_sum;
    logic                         overflow;
    logic [dcu_pkg::DELTA_W-1:0]  dzn;
    logic [18:0]                  dzs;
    logic [18:0]                  sz19;
    logic [19:0]                  sz_plus;
    logic                         is_max;
    logic                         infront;
    logic                         nearer;
    logic                         farther;
    logic [dcu_pkg::CODE_W-1:0]   scale;
    logic [dcu_pkg::DEPTH_W-1:0]  depth_diff;
    logic [7:0]                   product;
    logic [dcu_pkg::CODE_W-1:0]   b_diff;
    logic [dcu_pkg::SHIFT_W-1:0]  b_off;
    logic                         pass;
    logic                         blend;
    logic [dcu_pkg::COV_W-1:0]    cov_out;

    assign cov_sum  = {2'd0, item.stored_coverage} + {1'b0, item.coverage};
    assign overflow = cov_sum[3];

    assign dzn     = dcu_pkg::top_bit(item.delta_depth | dec.stored_delta);
    assign dzs     = {dzn, 3'd0};
    assign sz19    = {1'b0, item.new_depth};
    assign sz_plus = {2'd0, item.new_depth} + {1'b0, dzs};
    assign is_max  = dec.old_depth == dcu_pkg::DEPTH_MAX;
    assign infront = item.new_depth < dec.old_depth;
    assign nearer  = dec.coplanar || (sz19 < dzs)
                     || ((sz19 - dzs) <= {1'b0, dec.old_depth});
    assign farther = dec.coplanar || (sz_plus >= {2'd0, dec.old_depth});

    assign scale      = dcu_pkg::log2_pow2(dzn);
    assign depth_diff = (dec.old_depth >> scale) - (item.new_depth >> scale);
    assign product    = {4'd0, depth_diff[3:0]} * {4'd0, item.coverage};

    assign b_diff = dcu_pkg::CODE_MAX - item.delta_code;
    assign b_off  = (item.delta_code < dcu_pkg::CODE_SHIFT_LIM)
                    ? dcu_pkg::SHIFT_MAX : b_diff[dcu_pkg::SHIFT_W-1:0];

    always_comb
    begin
        state_next = state;
        cov_out    = item.coverage;
        pass       = 1'b1;
        if (cfg.compare_enable)
        begin
            if (cfg.shifters_update)
            begin
                state_next.shift_a = dcu_pkg::clamp_diff(item.delta_code, dec.stored_code);
                state_next.shift_b = dcu_pkg::clamp_diff(dec.stored_code, item.delta_code);
            end
            if (cfg.past_shifters_update)
            begin
                state_next.past_shift_a = dcu_pkg::clamp_diff(item.delta_code, state.prev_code);
                state_next.past_shift_b = dcu_pkg::clamp_diff(state.prev_code, item.delta_code);
            end
            state_next.prev_code = dec.stored_code;
            blend = cfg.blend_always || (!overflow && cfg.antialias_enable && farther);
            case (cfg.depth_mode)
                dcu_pkg::MODE_OPAQUE:
                    pass = is_max || (overflow ? infront : nearer);
                dcu_pkg::MODE_INTERPEN:
                begin
                    if (infront && farther && overflow)
                    begin
                        cov_out = product[6:3];
                        pass    = 1'b1;
                    end
                    else
                    begin
                        pass = is_max || (overflow ? infront : nearer);
                    end
                end
                dcu_pkg::MODE_TRANSLUCENT:
                    pass = infront || is_max;
                default:
                    pass = farther && nearer && !is_max;
            endcase
        end
        else
        begin
            if (cfg.shifters_update)
            begin
                state_next.shift_a = '0;
                state_next.shift_b = b_off;
            end
            if (cfg.past_shifters_update)
            begin
                state_next.past_shift_a = '0;
                state_next.past_shift_b = b_off;
            end
            state_next.prev_code = dcu_pkg::CODE_MAX;
            blend = cfg.blend_always || (!overflow && cfg.antialias_enable);
        end
    end

    always_comb
    begin
        res.pass          = pass;
        res.blend_enable  = blend;
        res.coverage_wrap = overflow;
        res.coverage_out  = cov_out;
        res.shift_a       = state_next.shift_a;
        res.shift_b       = state_next.shift_b;
        res.past_shift_a  = state_next.past_shift_a;
        res.past_shift_b  = state_next.past_shift_b;
    end

endmodule

// ----- src/depth_compare_unit_top.sv -----
// depth compare unit: input register, single-pass test logic, result register
// a pixel beat is captured in the input register, then moves into the result register once that is free
// throughput: one pixel per cycle unless result.ready stalls the output, set by the one pass of decode and compare
// logic between the input register and the result register
// reset clears the valid bits, the configuration and the carried slope/shift state
// depends on dcu_pkg, dcu_pixel_if, dcu_result_if, dcu_depth_decode, dcu_compare

module depth_compare_unit_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dcu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcu_pkg::CFG_DATA_W-1:0] cfg_data,
    dcu_pixel_if.sink                      pixel,
    dcu_result_if.source                   result
);

    dcu_pkg::cfg_t     cfg_reg;
    dcu_pkg::item_t    item_reg;
    logic              s1_valid_reg;
    dcu_pkg::result_t  result_reg;
    logic              s2_valid_reg;
    dcu_pkg::state_t   state_reg;
    dcu_pkg::state_t   state_next;
    dcu_pkg::result_t  result_next;
    dcu_pkg::decoded_t dec;
    logic              pixel_accept;
    logic              s2_load;

    assign s2_load      = s1_valid_reg && (!s2_valid_reg || result.ready);
    assign pixel.ready  = !s1_valid_reg || s2_load;
    assign pixel_accept = pixel.valid && pixel.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{compare_enable: 1'b0, depth_mode: dcu_pkg::MODE_OPAQUE,
                         blend_always: 1'b0, antialias_enable: 1'b0,
                         shifters_update: 1'b0, past_shifters_update: 1'b0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dcu_pkg::CFG_COMPARE_ENABLE:       cfg_reg.compare_enable <= cfg_data[0];
                dcu_pkg::CFG_DEPTH_MODE:
                    cfg_reg.depth_mode <= dcu_pkg::depth_mode_t'(cfg_data[1:0]);
                dcu_pkg::CFG_BLEND_ALWAYS:         cfg_reg.blend_always <= cfg_data[0];
                dcu_pkg::CFG_ANTIALIAS_ENABLE:     cfg_reg.antialias_enable <= cfg_data[0];
                dcu_pkg::CFG_SHIFTERS_UPDATE:      cfg_reg.shifters_update <= cfg_data[0];
                dcu_pkg::CFG_PAST_SHIFTERS_UPDATE:
                    cfg_reg.past_shifters_update <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixel_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            item_reg <= '{new_depth: pixel.new_depth, delta_depth: pixel.delta_depth,
                          delta_code: pixel.delta_code, coverage: pixel.coverage,
                          stored_coverage: pixel.stored_coverage,
                          stored_word: pixel.stored_word,
                          stored_hidden: pixel.stored_hidden};
        end
    end

    dcu_depth_decode u_decode (
        .stored_word   (item_reg.stored_word),
        .stored_hidden (item_reg.stored_hidden),
        .dec           (dec)
    );

    dcu_compare u_compare (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .dec        (dec),
        .state      (state_reg),
        .res        (result_next),
        .state_next (state_next)
    );

    // carried state advances once per pixel, as it moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= '0;
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            state_reg    <= state_next;
            s2_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid         = s2_valid_reg;
    assign result.pass          = result_reg.pass;
    assign result.blend_enable  = result_reg.blend_enable;
    assign result.coverage_wrap = result_reg.coverage_wrap;
    assign result.coverage_out  = result_reg.coverage_out;
    assign result.shift_a       = result_reg.shift_a;
    assign result.shift_b       = result_reg.shift_b;
    assign result.past_shift_a  = result_reg.past_shift_a;
    assign result.past_shift_b  = result_reg.past_shift_b;

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    a_load_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> s2_valid_reg)
        else $error("result register not valid after a load");

    a_disabled_code: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_load && !cfg_reg.compare_enable) |=> (state_reg.prev_code == dcu_pkg::CODE_MAX))
        else $error("stored slope code not forced to maximum with compare off");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (result_reg.shift_a <= dcu_pkg::SHIFT_MAX
                          && result_reg.shift_b <= dcu_pkg::SHIFT_MAX
                          && result_reg.past_shift_a <= dcu_pkg::SHIFT_MAX
                          && result_reg.past_shift_b <= dcu_pkg::SHIFT_MAX))
        else $error("blender shift amount out of range");

endmodule
